/* rtl/core/scalar_kalman_snr_filter_macros.svh */
// Assertion macros shared by the filter RTL.
`ifndef SCALAR_KALMAN_SNR_FILTER_MACROS_SVH
`define SCALAR_KALMAN_SNR_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is high.
`define SKF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define SKF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SKF_ASSERT(lbl, clk, rst, prop, msg)
`define SKF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/skf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package skf_pkg;

   // Default fraction bits of the Q formats.
   localparam int FRACTION_BITS_DEF = 8;

   // Field and datapath widths.
   localparam int VAL_W   = 16;                 // Q8.8 values
   localparam int PRIOR_W = VAL_W + 1;          // covariance + process noise
   localparam int DEN_W   = PRIOR_W + 1;        // prior + measurement noise
   localparam int GAIN_W  = 17;                 // Q1.16, one included
   localparam int NUM_W   = PRIOR_W + 16 + 1;   // (prior << 16) + denom / 2
   localparam int INNOV_W = VAL_W + 1;
   localparam int MUL_W   = 18;                 // signed multiplier operand
   localparam int PROD_W  = 2 * MUL_W;

   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASUREMENT_NOISE = 1'b1;

   // Sequencer states.
   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_DIV     = 5'b00010,
      S_MUL_EST = 5'b00100,
      S_MUL_COV = 5'b01000,
      S_DONE    = 5'b10000
   } state_type;

   // Divider status seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } skf_div_stat_type;

endpackage
`default_nettype wire

/* rtl/core/skf_div.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "scalar_kalman_snr_filter_macros.svh"
// Restoring divider: one compare/subtract per cycle, one quotient bit per cycle.
module skf_div
   import skf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_W-1:0]    numerator,
   input  wire logic [DEN_W-1:0]    divisor,
   output      logic [GAIN_W-1:0]   quotient,
   output      skf_div_stat_type    stat
);

   localparam int CntW = $clog2(GAIN_W + 1);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [GAIN_W-1:0] low_ff, low_in;
   logic [GAIN_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0]  dsr_ff, dsr_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              done_ff, done_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           fits;

   // Shared compare/subtract unit
   always_comb begin
      trial = {rem_ff, low_ff[GAIN_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = trial >= {1'b0, dsr_ff};
   end

   // Step control
   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         // high part is below the divisor, so the quotient fits GAIN_W bits
         rem_in = DEN_W'(numerator[NUM_W-1:GAIN_W]);
         low_in = numerator[GAIN_W-1:0];
         quo_in = '0;
         dsr_in = divisor;
         cnt_in = CntW'(GAIN_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         low_in  = {low_ff[GAIN_W-2:0], 1'b0};
         quo_in  = {quo_ff[GAIN_W-2:0], fits};
         cnt_in  = cnt_ff - CntW'(1);
         done_in = (cnt_ff == CntW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

   `SKF_ASSERT(a_div_done_pulse, clock, reset, stat.done |=> !stat.done, "divider done held")
   `SKF_ASSERT(a_div_start_busy, clock, reset, start |=> stat.busy, "divider did not start")
   `SKF_ASSERT(a_div_no_restart, clock, reset, stat.busy |-> !start, "divider restarted while busy")

endmodule
`default_nettype wire

/* rtl/core/skf_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared signed multiplier with a registered product.
module skf_mul
   import skf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     enable,
   input  wire logic signed [MUL_W-1:0]  op_a,
   input  wire logic signed [MUL_W-1:0]  op_b,
   output      logic signed [PROD_W-1:0] product
);

   logic signed [PROD_W-1:0] product_ff, product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule
`default_nettype wire

/* rtl/core/scalar_kalman_snr_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "scalar_kalman_snr_filter_macros.svh"
// Channel   Direction  Handshake          Payload
// req       in         req_valid/ready    measurement (s16 Q8.8)
// rsp       out        rsp_valid/ready    estimate, covariance, gain
// csr       in         csr_wr_en          csr_index, csr_wr_data (write only)
//
// Per measurement: setup on transfer, then the serial gain divider (one
// quotient bit a cycle), two products on the shared multiplier and the
// result load. req_ready is high only while idle.
// Reset (synchronous) clears the estimate to 0, sets covariance and both
// noise registers to 1.0. A stalled rsp keeps the finished item in DONE.
module scalar_kalman_snr_filter
   import skf_pkg::*;
#(
   parameter int FractionBits = FRACTION_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire logic signed [VAL_W-1:0] req_measurement,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      logic signed [VAL_W-1:0] rsp_estimate,
   output      logic [VAL_W-1:0]        rsp_covariance,
   output      logic [GAIN_W-1:0]       rsp_gain,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [VAL_W-1:0]        csr_wr_data
);

   localparam logic [VAL_W-1:0] OneValue = VAL_W'(1 << FractionBits);
   localparam int ShiftW = PROD_W - 16;

   state_type state_ff, state_in;

   logic [VAL_W-1:0]        pnoise_ff, mnoise_ff;
   logic signed [VAL_W-1:0] est_reg_ff;
   logic [VAL_W-1:0]        cov_reg_ff;

   logic [PRIOR_W-1:0]        prior_ff;
   logic                      dzero_ff;
   logic signed [INNOV_W-1:0] innov_ff;
   logic [GAIN_W-1:0]         gain_ff, gain_in;
   logic signed [VAL_W-1:0]   est_ff, est_in;

   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] rsp_est_ff;
   logic [VAL_W-1:0]        rsp_cov_ff;
   logic [GAIN_W-1:0]       rsp_gain_ff;

   logic               accept;
   logic               load_out;
   logic [PRIOR_W-1:0] prior;
   logic [DEN_W-1:0]   denom;
   logic [NUM_W-1:0]   numer;

   logic [GAIN_W-1:0]     quotient;
   skf_div_stat_type      div_stat;

   logic                     mul_en;
   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0] product;

   logic signed [PROD_W-1:0] est_sum;
   logic signed [ShiftW-1:0] est_adj;
   logic signed [ShiftW-1:0] est_wide;
   logic [PROD_W-1:0]        cov_sum;
   logic [ShiftW-1:0]        cov_wide;
   logic [VAL_W-1:0]         cov_sat;

   assign accept   = req_valid && req_ready;
   assign load_out = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Prior, gain denominator and rounded dividend
   always_comb begin
      prior = PRIOR_W'(cov_reg_ff) + PRIOR_W'(pnoise_ff);
      denom = DEN_W'(prior) + DEN_W'(mnoise_ff);
      numer = NUM_W'({prior, 16'd0}) + NUM_W'(denom[DEN_W-1:1]);
   end

   skf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .numerator (numer),
      .divisor   (denom),
      .quotient  (quotient),
      .stat      (div_stat)
   );

   // Multiplier operands: gain * innovation, then (1 - gain) * prior
   always_comb begin
      mul_en = 1'b0;
      op_a   = '0;
      op_b   = '0;
      if (state_ff == S_MUL_EST) begin
         mul_en = 1'b1;
         op_a   = MUL_W'(gain_ff);
         op_b   = MUL_W'(innov_ff);
      end else if (state_ff == S_MUL_COV) begin
         mul_en = 1'b1;
         op_a   = MUL_W'(GAIN_ONE - gain_ff);
         op_b   = MUL_W'(prior_ff);
      end
   end

   skf_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   // Gain clamp (zero for a zero denominator), estimate rounding and saturation, covariance rounding and saturation
   always_comb begin
      if (dzero_ff) begin
         gain_in = '0;
      end else if (quotient > GAIN_ONE) begin
         gain_in = GAIN_ONE;
      end else begin
         gain_in = quotient;
      end

      est_sum  = product + PROD_W'(32768);
      est_adj  = est_sum[PROD_W-1:16];
      est_wide = ShiftW'(est_reg_ff) + est_adj;
      if (est_wide > ShiftW'(32767)) begin
         est_in = VAL_W'(16'h7fff);
      end else if (est_wide < -ShiftW'(32768)) begin
         est_in = VAL_W'(16'h8000);
      end else begin
         est_in = est_wide[VAL_W-1:0];
      end

      cov_sum  = product + PROD_W'(32768);
      cov_wide = cov_sum[PROD_W-1:16];
      cov_sat  = (|cov_wide[ShiftW-1:VAL_W]) ? '1 : cov_wide[VAL_W-1:0];
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (accept) state_in = S_DIV;
         S_DIV:     if (div_stat.done) state_in = S_MUL_EST;
         S_MUL_EST: state_in = S_MUL_COV;
         S_MUL_COV: state_in = S_DONE;
         S_DONE:    if (load_out) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pnoise_ff    <= OneValue;
         mnoise_ff    <= OneValue;
         est_reg_ff   <= '0;
         cov_reg_ff   <= OneValue;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_PROCESS_NOISE:     pnoise_ff <= csr_wr_data;
               CSR_MEASUREMENT_NOISE: mnoise_ff <= csr_wr_data;
               default:               ;
            endcase
         end
         if (load_out) begin
            est_reg_ff   <= est_ff;
            cov_reg_ff   <= cov_sat;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         prior_ff <= prior;
         dzero_ff <= (denom == '0);
         innov_ff <= INNOV_W'(req_measurement) - INNOV_W'(est_reg_ff);
      end
      if (state_ff == S_DIV && div_stat.done) begin
         gain_ff <= gain_in;
      end
      if (state_ff == S_MUL_COV) begin
         est_ff <= est_in;
      end
      if (load_out) begin
         rsp_est_ff  <= est_ff;
         rsp_cov_ff  <= cov_sat;
         rsp_gain_ff <= gain_ff;
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_estimate   = rsp_est_ff;
   assign rsp_covariance = rsp_cov_ff;
   assign rsp_gain       = rsp_gain_ff;

   `SKF_ASSERT(a_ready_div_idle, clock, reset, req_ready |-> !div_stat.busy, "ready while dividing")
   `SKF_ASSERT(a_gain_range, clock, reset, rsp_valid |-> (rsp_gain <= GAIN_ONE), "gain above one")
   `SKF_ASSERT(a_accept_div, clock, reset, accept |=> (state_ff == S_DIV && div_stat.busy), "transfer did not start divider")
   `SKF_ASSERT(a_done_in_div, clock, reset, div_stat.done |-> (state_ff == S_DIV), "divider done outside DIV")

endmodule
`default_nettype wire

/* tb/skf_checker.sv */
`timescale 1ns / 1ps
module skf_checker
   import skf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic signed [VAL_W-1:0] req_measurement,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [VAL_W-1:0] rsp_estimate,
   input  logic [VAL_W-1:0]        rsp_covariance,
   input  logic [GAIN_W-1:0]       rsp_gain,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [VAL_W-1:0]        csr_wr_data,
   output int                      fail_count,
   output int                      pending_count
);

   localparam logic [VAL_W-1:0] UNITY_Q = VAL_W'(1 << FRACTION_BITS_DEF);

   typedef struct packed {
      logic signed [VAL_W-1:0] estimate;
      logic [VAL_W-1:0]        covariance;
      logic [GAIN_W-1:0]       gain;
   } filter_result_type;

   // Shadow of the filter state and the noise registers
   logic signed [VAL_W-1:0] est_state;
   logic [VAL_W-1:0]        cov_state;
   logic [VAL_W-1:0]        process_var;
   logic [VAL_W-1:0]        meas_var;

   filter_result_type       filter_outputs_q[$];

   // One Kalman step: prior, gain, estimate and covariance update
   function automatic filter_result_type filter_update(input logic signed [VAL_W-1:0] meas);
      longint            prior;
      longint            denom;
      longint            k;
      longint            innov;
      longint            est;
      longint            cov;
      filter_result_type res;
      prior = longint'(cov_state) + longint'(process_var);
      denom = prior + longint'(meas_var);
      if (denom == 0) begin
         // undefined quotient: gain forced to zero
         k = 0;
      end else begin
         k = ((prior << 16) + denom / 2) / denom;
      end
      if (k > 65536) begin
         k = 65536;
      end
      innov = longint'(meas) - longint'(est_state);
      // longint is signed, so the arithmetic shift rounds toward minus infinity
      est = longint'(est_state) + ((k * innov + 32768) >>> 16);
      if (est > 32767) begin
         est = 32767;
      end
      if (est < -32768) begin
         est = -32768;
      end
      cov = ((65536 - k) * prior + 32768) >>> 16;
      if (cov > 65535) begin
         cov = 65535;
      end
      est_state      = VAL_W'(est);
      cov_state      = VAL_W'(cov);
      res.estimate   = VAL_W'(est);
      res.covariance = VAL_W'(cov);
      res.gain       = GAIN_W'(k);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // Monitor: predict on each request transfer, compare on each response transfer
   always @(posedge clock) begin
      filter_result_type want;
      if (reset) begin
         est_state   = '0;
         cov_state   = UNITY_Q;
         process_var = UNITY_Q;
         meas_var    = UNITY_Q;
         filter_outputs_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PROCESS_NOISE:     process_var = csr_wr_data;
               CSR_MEASUREMENT_NOISE: meas_var    = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (filter_outputs_q.size() == 0) begin
               report_mismatch("unexpected result, estimate", longint'(rsp_estimate), 0);
            end else begin
               want = filter_outputs_q.pop_front();
               if (rsp_estimate !== want.estimate) begin
                  report_mismatch("estimate", longint'(rsp_estimate),
                                  longint'(want.estimate));
               end
               if (rsp_covariance !== want.covariance) begin
                  report_mismatch("covariance", longint'(rsp_covariance),
                                  longint'(want.covariance));
               end
               if (rsp_gain !== want.gain) begin
                  report_mismatch("gain", longint'(rsp_gain), longint'(want.gain));
               end
            end
         end
         if (req_valid && req_ready) begin
            filter_outputs_q.push_back(filter_update(req_measurement));
         end
      end
      pending_count = filter_outputs_q.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import skf_pkg::*;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STALL_LIMIT     = 3000;
   localparam int PHASE_ITEMS     = 185;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [VAL_W-1:0] req_measurement = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [VAL_W-1:0] rsp_estimate;
   logic [VAL_W-1:0]        rsp_covariance;
   logic [GAIN_W-1:0]       rsp_gain;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_PROCESS_NOISE;
   logic [VAL_W-1:0]        csr_wr_data = '0;

   int fail_count;
   int pending_count;
   int idle_pct = 0;
   int sink_stall_pct = 0;
   int hold_req_cnt = 0;
   int hold_seen = 0;
   int quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   scalar_kalman_snr_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_measurement(req_measurement),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_estimate   (rsp_estimate),
      .rsp_covariance (rsp_covariance),
      .rsp_gain       (rsp_gain),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   skf_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_measurement(req_measurement),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_estimate   (rsp_estimate),
      .rsp_covariance (rsp_covariance),
      .rsp_gain       (rsp_gain),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   // Watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("scalar_kalman_snr_filter test failed");
            $finish;
         end
      end
   end

   // Response sink: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req_cnt != hold_seen) begin
            hold_seen = hold_req_cnt;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // Offer one measurement and hold it until the transfer
   task automatic offer_measurement(input logic signed [VAL_W-1:0] value);
      bit taken;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid       <= 1'b1;
      req_measurement <= value;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_ready;
      end
      @(negedge clock);
   endtask

   // Stop offering until every predicted result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // Write both noise registers, block idle
   task automatic write_noise(input logic [VAL_W-1:0] proc_var, input logic [VAL_W-1:0] meas_var);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PROCESS_NOISE;
      csr_wr_data <= proc_var;
      @(negedge clock);
      csr_index   <= CSR_MEASUREMENT_NOISE;
      csr_wr_data <= meas_var;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [VAL_W-1:0] pick_noise();
      case ($urandom_range(5))
         0:       return '0;
         1:       return 16'hFFFF;
         2:       return VAL_W'($urandom_range(1024));
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // Mostly a noisy steady level, some full-range samples and extremes
   function automatic logic signed [VAL_W-1:0] pick_measurement(input int level);
      int v;
      case ($urandom_range(9))
         0, 1, 2: return VAL_W'($urandom);
         3:       return ($urandom_range(1) != 0) ? 16'sh7FFF : -16'sh8000;
         default: begin
            v = level + int'($urandom_range(1024)) - 512;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return VAL_W'(v);
         end
      endcase
   endfunction

   initial begin
      int level;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes at reset noise settings
      offer_measurement(16'sh7FFF);
      offer_measurement(-16'sh8000);
      offer_measurement(16'sh0000);
      offer_measurement(16'sh0001);
      offer_measurement(-16'sh0001);
      offer_measurement(16'sh0100);
      // zero measurement noise: unity gain, covariance collapses to zero
      wait_drained();
      write_noise(16'd256, 16'd0);
      offer_measurement(16'sd1000);
      offer_measurement(-16'sd5000);
      // zero prior and zero measurement noise: gain forced to zero
      wait_drained();
      write_noise(16'd0, 16'd0);
      offer_measurement(16'sd12345);
      offer_measurement(-16'sh8000);
      // largest noise on both sides
      wait_drained();
      write_noise(16'hFFFF, 16'hFFFF);
      offer_measurement(16'sh7FFF);
      offer_measurement(-16'sh8000);
      offer_measurement(16'sh7FFF);
      offer_measurement(16'sh5555);
      wait_drained();
      write_noise(16'd0, 16'hFFFF);
      offer_measurement(-16'sh8000);
      offer_measurement(16'sh7FFF);
      offer_measurement(16'sh0000);
      wait_drained();
      write_noise(16'hFFFF, 16'd0);
      offer_measurement(16'sh7FFF);
      offer_measurement(-16'sh8000);
      wait_drained();
      write_noise(16'd1, 16'd1);
      offer_measurement(16'sh0001);
      offer_measurement(-16'sh0001);

      // Random phases, cycling through the idle patterns
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         write_noise(pick_noise(), pick_noise());
         case (phase % 4)
            0: begin idle_pct = 0;  sink_stall_pct <= 0;  end
            1: begin idle_pct = 85; sink_stall_pct <= 0;  end
            2: begin idle_pct = 0;  sink_stall_pct <= 85; end
            default: begin idle_pct = 15; sink_stall_pct <= 15; end
         endcase
         level = int'($urandom_range(16000)) - 4000;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // long sink hold-off while requests keep coming
            if (phase == 0 && i == 60) begin
               hold_req_cnt <= hold_req_cnt + 1;
            end
            // sender pause until the pipeline is empty
            if (phase == 2 && i == 100) begin
               wait_drained();
            end
            if (i % 50 == 49) begin
               level = int'($urandom_range(16000)) - 4000;
            end
            offer_measurement(pick_measurement(level));
         end
      end

      wait_drained();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("scalar_kalman_snr_filter test passed");
      end else begin
         $display("scalar_kalman_snr_filter test failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/skf_pkg.sv
rtl/core/skf_div.sv
rtl/core/skf_mul.sv
rtl/core/scalar_kalman_snr_filter.sv
tb/skf_checker.sv
tb/tb_top.sv
